// ===== rtl/core/box_downscale_2x_rotate_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 box downscaler
// Each macro expands to a labeled concurrent assertion on a rising clock edge,
// disabled while the active-low reset is asserted. Defining NO_ASSERTIONS
// turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSCALE_2X_ROTATE_MACROS_SVH
`define BOX_DOWNSCALE_2X_ROTATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define BDSR_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BDSR_FORBID(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error(msg);

`else

`define BDSR_ASSERT(lbl, clk, rstn, prop, msg)
`define BDSR_FORBID(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/core/bdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsr_pkg
// Shared widths, reset values, register indexes and types of the 2x2 box
// downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdsr_pkg;

	// Fixed field widths.
	localparam int PIX_W     = 32;
	localparam int IDX_W     = 18;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// Default size limits of the source frame.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Register reset values.
	localparam int RST_SCREEN_WIDTH  = 320;
	localparam int RST_SCREEN_HEIGHT = 256;

	// Per-channel quarter mask after the shift by two.
	localparam logic [PIX_W-1:0] QUARTER_MASK = 32'h3F3F_3F3F;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PORTRAIT_MODE = 2'd2;

	// Control bits of one item on its way from the scan stage to the
	// accumulate stage.
	typedef struct packed {
		logic first;      // top-left pixel of a block: start a new sum
		logic emit;       // pixel closes its block: give a result
		logic frame_end;  // last pixel of the frame
	} item_ctl_t;

	// Address bits of the line store for a given maximum width.
	function automatic int slot_bits(input int max_width);
		int depth;
		depth = (max_width + 1) >> 1;
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== rtl/core/box_downscale_2x_rotate.sv =====
// ----------------------------------------------------------------------------
// box_downscale_2x_rotate
// 2x2 box-filter downscaler for a raster stream of 32-bit RGBA pixels. Each
// byte channel is divided by four and the four pixels of every 2x2 block are
// summed into one destination pixel, tagged with its linear index (normal or
// portrait layout) and a last-of-frame flag; blocks cut short by an odd last
// column or row are given with the pixels they have. The block takes one
// pixel per clock unless in_stall is high: every pixel is a read of the line
// store in the first stage and an add and write-back in the second, and the
// sum written in one cycle is forwarded to a read of the same slot issued in
// that cycle. A closing pixel is registered in the second stage, and its
// result is loaded into the output register when that stage moves on, which
// a waiting, stalled output delays. Input stalls only while a finished result
// is held in the second stage behind a waiting, stalled output. The line store
// holds (MAX_WIDTH+1)/2 sums of 32 bits; it needs no clearing after reset,
// since even rows fill it before odd rows read it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_downscale_2x_rotate #(
	parameter int MAX_WIDTH  = bdsr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bdsr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bdsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdsr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bdsr_pkg::PIX_W-1:0]     pixel_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bdsr_pkg::IDX_W-1:0]     dest_index,
	output logic [bdsr_pkg::PIX_W-1:0]     dest_value,
	output logic                           frame_last
);

	localparam int AW        = bdsr_pkg::slot_bits(MAX_WIDTH);
	localparam int ACC_DEPTH = (MAX_WIDTH + 1) / 2;

	logic                       accept;
	logic                       hold;
	logic [AW-1:0]              slot;
	logic [bdsr_pkg::PIX_W-1:0] quarter;
	bdsr_pkg::item_ctl_t        ctl;
	logic [bdsr_pkg::IDX_W-1:0] mul_a;
	logic [bdsr_pkg::IDX_W-1:0] mul_b;
	logic [bdsr_pkg::IDX_W-1:0] add_c;
	logic [bdsr_pkg::PIX_W-1:0] rd_data;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [bdsr_pkg::PIX_W-1:0] wr_data;

	// Item handshake on the input side.
	assign in_stall = hold;
	assign accept   = in_valid & ~hold;

	// Counters, configuration and first stage.
	bdsr_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.pixel_value(pixel_value),
		.slot       (slot),
		.quarter    (quarter),
		.ctl        (ctl),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.add_c      (add_c)
	);

	// Line store of partial block sums.
	bdsr_ram #(
		.WIDTH (bdsr_pkg::PIX_W),
		.DEPTH (ACC_DEPTH),
		.ADDR_W(AW)
	) u_line_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (accept),
		.raddr(slot),
		.rdata(rd_data)
	);

	// Accumulate stage and output register.
	bdsr_accum #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.slot      (slot),
		.quarter   (quarter),
		.ctl       (ctl),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.add_c     (add_c),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.hold      (hold),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.dest_index(dest_index),
		.dest_value(dest_value),
		.frame_last(frame_last)
	);

endmodule

// ===== rtl/core/bdsr_ram.sv =====
// ----------------------------------------------------------------------------
// bdsr_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bdsr_scan.sv =====
// ----------------------------------------------------------------------------
// bdsr_scan
// Configuration registers, raster counters and the first stage of the item:
// clamps the position to the frame, quarters the pixel, finds its slot in
// the line store and prepares the operands of the destination index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_downscale_2x_rotate_macros.svh"

module bdsr_scan #(
	parameter int MAX_WIDTH  = bdsr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bdsr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_write,
	input  logic [bdsr_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [bdsr_pkg::CFG_W-1:0]                  cfg_data,
	input  logic                                        accept,
	input  logic [bdsr_pkg::PIX_W-1:0]                  pixel_value,
	output logic [bdsr_pkg::slot_bits(MAX_WIDTH)-1:0]   slot,
	output logic [bdsr_pkg::PIX_W-1:0]                  quarter,
	output bdsr_pkg::item_ctl_t                         ctl,
	output logic [bdsr_pkg::IDX_W-1:0]                  mul_a,
	output logic [bdsr_pkg::IDX_W-1:0]                  mul_b,
	output logic [bdsr_pkg::IDX_W-1:0]                  add_c
);

	localparam int AW  = bdsr_pkg::slot_bits(MAX_WIDTH);
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int DHW = HW + 1;
	localparam int RST_W = (bdsr_pkg::RST_SCREEN_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : bdsr_pkg::RST_SCREEN_WIDTH;
	localparam int RST_H = (bdsr_pkg::RST_SCREEN_HEIGHT > MAX_HEIGHT) ?
		MAX_HEIGHT : bdsr_pkg::RST_SCREEN_HEIGHT;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic          portrait_q;
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	logic [WW-1:0] width_sat;
	logic [HW-1:0] height_sat;
	logic [XW-1:0] x_pos;
	logic [YW-1:0] y_pos;
	logic          last_col;
	logic          last_row;
	logic          col_close;
	logic          row_close;
	logic [WW:0]   dw;
	logic [HW:0]   dh;
	logic [HW:0]   rot_c;
	logic [AW-1:0] dx;
	logic [YW-1:0] dy;

	// Sizes are stored already clamped to the range one to the maximum.
	always_comb begin
		if (cfg_data == '0) begin
			width_sat  = WW'(1);
			height_sat = HW'(1);
		end else begin
			width_sat  = (32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
			height_sat = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WW'(RST_W);
			height_q   <= HW'(RST_H);
			portrait_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				bdsr_pkg::REG_SCREEN_WIDTH:  width_q    <= width_sat;
				bdsr_pkg::REG_SCREEN_HEIGHT: height_q   <= height_sat;
				bdsr_pkg::REG_PORTRAIT_MODE: portrait_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A count left beyond a frame that has shrunk acts as the last column
	// or row.
	assign x_pos = (WW'(col_q) >= width_q) ? XW'(width_q - WW'(1)) : col_q;
	assign y_pos = (HW'(row_q) >= height_q) ? YW'(height_q - HW'(1)) : row_q;

	assign last_col  = (WW'(x_pos) == width_q - WW'(1));
	assign last_row  = (HW'(y_pos) == height_q - HW'(1));
	assign col_close = x_pos[0] | last_col;
	assign row_close = y_pos[0] | last_row;

	// Raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : YW'(y_pos + YW'(1));
			end else begin
				col_q <= XW'(x_pos + XW'(1));
				row_q <= y_pos;
			end
		end
	end

	// Block coordinates and destination size.
	assign dx    = AW'(x_pos >> 1);
	assign dy    = y_pos >> 1;
	assign dw    = ({1'b0, width_q} + 1'b1) >> 1;
	assign dh    = ({1'b0, height_q} + 1'b1) >> 1;
	assign rot_c = dh - DHW'(1) - DHW'(dy);

	// Index operands: dy*DW+dx, or dx*DH+(DH-1-dy) when rotated.
	always_comb begin
		if (portrait_q) begin
			mul_a = bdsr_pkg::IDX_W'(dx);
			mul_b = bdsr_pkg::IDX_W'(dh);
			add_c = bdsr_pkg::IDX_W'(rot_c);
		end else begin
			mul_a = bdsr_pkg::IDX_W'(dy);
			mul_b = bdsr_pkg::IDX_W'(dw);
			add_c = bdsr_pkg::IDX_W'(dx);
		end
	end

	assign slot          = dx;
	assign quarter       = (pixel_value >> 2) & bdsr_pkg::QUARTER_MASK;
	assign ctl.first     = ~x_pos[0] & ~y_pos[0];
	assign ctl.emit      = col_close & row_close;
	assign ctl.frame_end = last_col & last_row;

	`BDSR_ASSERT(a_frame_wraps, clk, arst_n, accept && ctl.frame_end |=> col_q == '0 && row_q == '0, "counters did not wrap at frame end")
	`BDSR_ASSERT(a_count_in_frame, clk, arst_n, accept && !cfg_write |=> WW'(col_q) < width_q && HW'(row_q) < height_q, "counter left the frame")

endmodule

// ===== rtl/core/bdsr_accum.sv =====
// ----------------------------------------------------------------------------
// bdsr_accum
// Second stage of the item: read-modify-write of the line store with
// forwarding of the sum written in the cycle of the read, the destination
// index and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_downscale_2x_rotate_macros.svh"

module bdsr_accum #(
	parameter int MAX_WIDTH = bdsr_pkg::DEF_MAX_WIDTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      accept,
	input  logic [bdsr_pkg::slot_bits(MAX_WIDTH)-1:0] slot,
	input  logic [bdsr_pkg::PIX_W-1:0]                quarter,
	input  bdsr_pkg::item_ctl_t                       ctl,
	input  logic [bdsr_pkg::IDX_W-1:0]                mul_a,
	input  logic [bdsr_pkg::IDX_W-1:0]                mul_b,
	input  logic [bdsr_pkg::IDX_W-1:0]                add_c,
	input  logic [bdsr_pkg::PIX_W-1:0]                rd_data,
	output logic                                      wr_en,
	output logic [bdsr_pkg::slot_bits(MAX_WIDTH)-1:0] wr_addr,
	output logic [bdsr_pkg::PIX_W-1:0]                wr_data,
	output logic                                      hold,
	input  logic                                      out_stall,
	output logic                                      out_valid,
	output logic [bdsr_pkg::IDX_W-1:0]                dest_index,
	output logic [bdsr_pkg::PIX_W-1:0]                dest_value,
	output logic                                      frame_last
);

	localparam int AW = bdsr_pkg::slot_bits(MAX_WIDTH);

	logic                           valid_s1;
	logic [AW-1:0]                  slot_s1;
	logic [bdsr_pkg::PIX_W-1:0]     pix_s1;
	bdsr_pkg::item_ctl_t            ctl_s1;
	logic [bdsr_pkg::IDX_W-1:0]     mul_a_s1;
	logic [bdsr_pkg::IDX_W-1:0]     mul_b_s1;
	logic [bdsr_pkg::IDX_W-1:0]     add_c_s1;
	logic                           hit_s1;
	logic [bdsr_pkg::PIX_W-1:0]     fwd_q;
	logic                           out_valid_q;
	logic [bdsr_pkg::IDX_W-1:0]     index_q;
	logic [bdsr_pkg::PIX_W-1:0]     value_q;
	logic                           last_q;

	logic                           go;
	logic [bdsr_pkg::PIX_W-1:0]     base;
	logic [bdsr_pkg::IDX_W-1:0]     index_calc;

	// The stage moves on unless its result would overwrite a waiting one.
	assign go   = ~valid_s1 | ~ctl_s1.emit | ~out_valid_q | ~out_stall;
	assign hold = valid_s1 & ~go;

	// Stage register; an item is only taken when the stage is free to move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Item payload; hit marks a write to the same slot at the read edge,
	// which the registered read does not yet see.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1  <= slot;
			pix_s1   <= quarter;
			ctl_s1   <= ctl;
			mul_a_s1 <= mul_a;
			mul_b_s1 <= mul_b;
			add_c_s1 <= add_c;
			hit_s1   <= wr_en && (wr_addr == slot);
		end
	end

	// Read-modify-write of the partial sum. Quartered channels never carry
	// across byte lanes, so one 32-bit add serves all four.
	assign base    = hit_s1 ? fwd_q : rd_data;
	assign wr_data = ctl_s1.first ? pix_s1 : base + pix_s1;
	assign wr_en   = valid_s1 & go;
	assign wr_addr = slot_s1;

	// Copy of the last sum written, for the forwarding path.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_q <= wr_data;
		end
	end

	assign index_calc = bdsr_pkg::IDX_W'(mul_a_s1 * mul_b_s1) + add_c_s1;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && ctl_s1.emit) begin
			index_q <= index_calc;
			value_q <= wr_data;
			last_q  <= ctl_s1.frame_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign dest_index = index_q;
	assign dest_value = value_q;
	assign frame_last = last_q;

	`BDSR_ASSERT(a_hold_keeps_item, clk, arst_n, hold |=> valid_s1 && $stable(slot_s1) && $stable(ctl_s1) && $stable(base), "held item changed")
	`BDSR_ASSERT(a_result_loaded, clk, arst_n, valid_s1 && ctl_s1.emit && go |=> out_valid_q, "closed block gave no result")
	`BDSR_FORBID(a_no_overwrite, clk, arst_n, wr_en && ctl_s1.emit && out_valid_q && out_stall, "waiting result overwritten")

endmodule
